// File: sv/tet_pkg.sv
// Package for the timer event table: sizes, codes and shared types.
// Used by the top level; depends on nothing.
package tet_pkg;
   localparam int TableEntries = 16;
   localparam int IdxW = $clog2(TableEntries);
   localparam int CntW = $clog2(TableEntries + 1);

   typedef enum logic [0:0] {FUNC_SCHEDULE = 1'b0, FUNC_ISSUE = 1'b1} func_type;
   typedef enum logic [1:0] {KIND_EVENT = 2'd0, KIND_STATUS = 2'd1, KIND_SUMMARY = 2'd2}
      kind_type;
   typedef enum logic [1:0] {ST_ADDED = 2'd0, ST_RESCHED = 2'd1, ST_FULL = 2'd2}
      status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_FIND, S_FIND_CHK, S_SCAN, S_SCAN_CHK, S_SHIFT, S_SHIFT_WR,
      S_SUMMARY, S_OUT
   } state_type;

   typedef struct packed {
      logic [31:0] id;
      logic [15:0] region;
      logic [31:0] trigger;
   } entry_type;

   localparam int EntryW = $bits(entry_type);

   // True when a - b is non-negative as a 32-bit signed value.
   function automatic logic not_before(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return ~d[31];
   endfunction
endpackage

// File: sv/tet_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module tet_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

// File: sv/timer_event_table_top.sv
// Top level of the timer event table: sequencer, entry RAM and compare unit.
// Depends on tet_pkg and tet_ram.
//
// The table keeps up to 16 timer entries in one single-port RAM and reads them
// one entry at a time. A schedule transaction ends sooner when an id matches
// than when none does. An issue transaction scans the table once for each due
// event, then compacts the table behind it, moving each later entry down one
// place, and hands the event to the output register. A scan that finds nothing
// due and a final scan of all entries give the summary. The cost is set by the
// single RAM port. The block takes no request while a transaction is in
// progress; each result waits in an output register until taken, and the
// sequencer waits only when it has a next result and the last one is still held.
module timer_event_table_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,  // component_id[31:0], region_tag[47:32], time_ms[79:48]
   input  logic         req_tuser,  // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,  // event_id, event_region, time_value, status,
                                    // pending, entry_count
   output logic [1:0]   rsp_tuser,  // kind
   output logic         rsp_tlast
);
   tet_pkg::state_type state_ff, state_in;
   logic [31:0]           id_ff, id_in, now_ff, now_in;
   logic [15:0]           reg_ff, reg_in;
   logic [tet_pkg::CntW-1:0] cnt_ff, cnt_in;
   logic [tet_pkg::CntW-1:0] idx_ff, idx_in;
   logic [tet_pkg::IdxW-1:0] best_ff, best_in;
   logic                  found_ff, found_in;
   tet_pkg::entry_type    bestent_ff, bestent_in;
   logic                  ovalid_ff, ovalid_in;
   logic [1:0]            okind_ff, okind_in, ostat_ff, ostat_in;
   logic [31:0]           oid_ff, oid_in, otime_ff, otime_in;
   logic [15:0]           oreg_ff, oreg_in;
   logic                  olast_ff, olast_in;
   logic                  done_ff, done_in;
   logic [tet_pkg::CntW-1:0] ocnt_ff;
   logic [1:0]            rkind_ff, rstat_ff;
   logic [31:0]           rid_ff, rtime_ff;
   logic [15:0]           rreg_ff;
   logic                  rlast_ff;

   logic                     ram_we;
   logic [tet_pkg::IdxW-1:0] ram_addr;
   tet_pkg::entry_type       ram_wd, ram_rd;
   logic                     due, better, idx_end;

   tet_ram #(.Width(tet_pkg::EntryW), .Depth(tet_pkg::TableEntries)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wd), .rd_data(ram_rd)
   );

   assign idx_end = (idx_ff == cnt_ff);
   assign due     = tet_pkg::not_before(now_ff, ram_rd.trigger);
   assign better  = !found_ff || tet_pkg::not_before(bestent_ff.trigger, ram_rd.trigger);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tet_pkg::S_IDLE: begin
            if (req_tvalid) state_in = (req_tuser == tet_pkg::FUNC_ISSUE) ?
                  tet_pkg::S_SCAN : tet_pkg::S_FIND;
         end
         tet_pkg::S_FIND:     state_in = idx_end ? tet_pkg::S_OUT : tet_pkg::S_FIND_CHK;
         tet_pkg::S_FIND_CHK: state_in = (ram_rd.id == id_ff) ? tet_pkg::S_OUT
                                                               : tet_pkg::S_FIND;
         tet_pkg::S_SCAN: begin
            if (idx_end) begin
               if (found_ff && !done_ff) state_in = tet_pkg::S_SHIFT;
               else if (!done_ff) state_in = tet_pkg::S_SCAN;
               else state_in = tet_pkg::S_SUMMARY;
            end else state_in = tet_pkg::S_SCAN_CHK;
         end
         tet_pkg::S_SCAN_CHK: state_in = tet_pkg::S_SCAN;
         tet_pkg::S_SHIFT:    state_in = idx_end ? tet_pkg::S_OUT : tet_pkg::S_SHIFT_WR;
         tet_pkg::S_SHIFT_WR: state_in = tet_pkg::S_SHIFT;
         tet_pkg::S_SUMMARY:  state_in = tet_pkg::S_OUT;
         tet_pkg::S_OUT: begin
            if (!ovalid_ff || rsp_tready)
               state_in = olast_ff ? tet_pkg::S_IDLE : tet_pkg::S_SCAN;
         end
         default: state_in = tet_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      id_in = id_ff; now_in = now_ff; reg_in = reg_ff;
      cnt_in = cnt_ff; idx_in = idx_ff; best_in = best_ff; found_in = found_ff;
      bestent_in = bestent_ff; done_in = done_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      okind_in = okind_ff; ostat_in = ostat_ff; oid_in = oid_ff; otime_in = otime_ff;
      oreg_in = oreg_ff; olast_in = olast_ff;
      ram_we = 1'b0;
      ram_addr = idx_ff[tet_pkg::IdxW-1:0];
      ram_wd = '{id: id_ff, region: reg_ff, trigger: now_ff};
      case (state_ff)
         tet_pkg::S_IDLE: begin
            if (req_tvalid) begin
               id_in = req_tdata[31:0];
               reg_in = req_tdata[47:32]; now_in = req_tdata[79:48];
               idx_in = '0; found_in = 1'b0; done_in = 1'b0;
            end
         end
         tet_pkg::S_FIND: begin
            if (idx_end) begin
               okind_in = tet_pkg::KIND_STATUS; oid_in = '0; oreg_in = '0; otime_in = '0;
               olast_in = 1'b1;
               if (cnt_ff < tet_pkg::CntW'(tet_pkg::TableEntries)) begin
                  ram_we = 1'b1; ram_addr = cnt_ff[tet_pkg::IdxW-1:0];
                  cnt_in = cnt_ff + 1'b1; ostat_in = tet_pkg::ST_ADDED;
               end else begin
                  ostat_in = tet_pkg::ST_FULL;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         tet_pkg::S_FIND_CHK: begin
            ram_addr = idx_ff[tet_pkg::IdxW-1:0] - 1'b1;
            if (ram_rd.id == id_ff) begin
               ram_we = 1'b1;
               ram_wd = '{id: ram_rd.id, region: ram_rd.region, trigger: now_ff};
               okind_in = tet_pkg::KIND_STATUS; oid_in = '0; oreg_in = '0; otime_in = '0;
               olast_in = 1'b1; ostat_in = tet_pkg::ST_RESCHED;
            end
         end
         tet_pkg::S_SCAN: begin
            if (idx_end) begin
               if (found_ff && !done_ff) begin
                  idx_in = {1'b0, best_ff} + 1'b1;
               end else begin
                  idx_in = '0;
                  done_in = 1'b1;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         tet_pkg::S_SCAN_CHK: begin
            if ((done_ff || due) && better) begin
               found_in = 1'b1; bestent_in = ram_rd;
               best_in = idx_ff[tet_pkg::IdxW-1:0] - 1'b1;
            end
         end
         tet_pkg::S_SHIFT: begin
            if (idx_end) begin
               cnt_in = cnt_ff - 1'b1;
               okind_in = tet_pkg::KIND_EVENT; oid_in = bestent_ff.id;
               oreg_in = bestent_ff.region; otime_in = bestent_ff.trigger;
               ostat_in = '0; olast_in = 1'b0;
               idx_in = '0; found_in = 1'b0;
            end
         end
         tet_pkg::S_SHIFT_WR: begin
            ram_we = 1'b1; ram_addr = idx_ff[tet_pkg::IdxW-1:0] - 1'b1;
            ram_wd = ram_rd; idx_in = idx_ff + 1'b1;
         end
         tet_pkg::S_SUMMARY: begin
            okind_in = tet_pkg::KIND_SUMMARY; oid_in = '0; oreg_in = '0;
            ostat_in = '0; olast_in = 1'b1;
            otime_in = (found_ff && tet_pkg::not_before(bestent_ff.trigger, now_ff)) ?
                       bestent_ff.trigger - now_ff : 32'd0;
         end
         tet_pkg::S_OUT: begin
            if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               idx_in = '0; found_in = 1'b0;
            end
         end
         default: ;
      endcase
      // Shift stage reads entry at idx for the following write cycle.
      if (state_ff == tet_pkg::S_SHIFT && !idx_end) ram_addr = idx_ff[tet_pkg::IdxW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tet_pkg::S_IDLE;
         cnt_ff <= '0;
         ovalid_ff <= 1'b0;
         olast_ff <= 1'b0;
         done_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         ovalid_ff <= ovalid_in;
         olast_ff <= olast_in;
         done_ff <= done_in;
         found_ff <= found_in;
      end
      id_ff <= id_in; now_ff <= now_in; reg_ff <= reg_in;
      idx_ff <= idx_in; best_ff <= best_in; bestent_ff <= bestent_in;
      okind_ff <= okind_in; ostat_ff <= ostat_in; oid_ff <= oid_in;
      otime_ff <= otime_in; oreg_ff <= oreg_in;
   end

   // The output register is loaded only when the previous result has left it.
   always_ff @(posedge clock) begin
      if (state_ff == tet_pkg::S_OUT && (!ovalid_ff || rsp_tready)) begin
         ocnt_ff <= cnt_ff;
         rkind_ff <= okind_ff;
         rstat_ff <= ostat_ff;
         rid_ff <= oid_ff;
         rtime_ff <= otime_ff;
         rreg_ff <= oreg_ff;
         rlast_ff <= olast_ff;
      end
   end

   assign req_tready = (state_ff == tet_pkg::S_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser  = rkind_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tdata  = {ocnt_ff, (ocnt_ff != '0), rstat_ff, rtime_ff, rreg_ff, rid_ff};
endmodule

// File: sv/tet_checker.sv
// Port-level checker for the timer event table, bound to the top level.
// Depends on the top level's ports only.
module tet_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   a_pend: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[82] == (rsp_tdata[87:83] != 5'd0)))
      else $error("pending disagrees with entry count");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[87:83] <= 5'd16)
      else $error("entry count beyond table size");
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == 2'd0 |-> !rsp_tlast)
      else $error("issued event marked last");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a transaction is in progress");
endmodule

bind timer_event_table_top tet_port_checker u_tet_checker (.*);
